// ----- rtl/hkrb_pkg.sv -----
// ----------------------------------------------------------------------------
// HID keyboard report builder package
// Shared types, command codes and the key code to HID usage lookup.
// ----------------------------------------------------------------------------
package hkrb_pkg;

  // Slot count default and the fixed number of usage fields in a report
  localparam int SLOT_COUNT_DEF = 6;
  localparam int MAX_SLOTS      = 6;

  // Event commands; the two remaining codes mean "other"
  typedef enum logic [1:0] {
    CMD_DOWN = 2'd0,
    CMD_UP   = 2'd1
  } hkrb_cmd_t;

  // Modifier select codes
  typedef enum logic [1:0] {
    MOD_NONE  = 2'd0,
    MOD_SHIFT = 2'd1,
    MOD_CTRL  = 2'd2,
    MOD_ALT   = 2'd3
  } hkrb_mod_sel_t;

  // Input word
  typedef struct packed {
    hkrb_cmd_t     cmd;
    hkrb_mod_sel_t modifier_select;
    logic [15:0]   key_code;
  } hkrb_in_t;

  // Result word
  typedef struct packed {
    logic [2:0] modifier_bits;
    logic [7:0] usage_one;
    logic [7:0] usage_two;
    logic [7:0] usage_three;
    logic [7:0] usage_four;
    logic [7:0] usage_five;
    logic [7:0] usage_six;
  } hkrb_out_t;

  // Held modifier flags
  typedef struct packed {
    logic alt;
    logic shift;
    logic ctrl;
  } hkrb_mods_t;

  // HID usage for ASCII codes 0x00..0x7F
  localparam logic [7:0] ASCII_USAGE [128] = '{
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h2A,8'h2B,8'h00,8'h00,8'h00,8'h28,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h29,8'h00,8'h00,8'h00,8'h00,
    8'h2C,8'h1E,8'h34,8'h20,8'h21,8'h22,8'h24,8'h34,
    8'h26,8'h27,8'h25,8'h2E,8'h36,8'h2D,8'h37,8'h38,
    8'h27,8'h1E,8'h1F,8'h20,8'h21,8'h22,8'h23,8'h24,
    8'h25,8'h26,8'h33,8'h33,8'h36,8'h2E,8'h37,8'h38,
    8'h1F,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h0A,
    8'h0B,8'h0C,8'h0D,8'h0E,8'h0F,8'h10,8'h11,8'h12,
    8'h13,8'h14,8'h15,8'h16,8'h17,8'h18,8'h19,8'h1A,
    8'h1B,8'h1C,8'h1D,8'h2F,8'h31,8'h30,8'h23,8'h2D,
    8'h35,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h0A,
    8'h0B,8'h0C,8'h0D,8'h0E,8'h0F,8'h10,8'h11,8'h12,
    8'h13,8'h14,8'h15,8'h16,8'h17,8'h18,8'h19,8'h1A,
    8'h1B,8'h1C,8'h1D,8'h2F,8'h31,8'h30,8'h35,8'h4C
  };

  // HID usage for special codes 0x100..0x15F, indexed by the low seven bits
  localparam logic [7:0] SPECIAL_USAGE [96] = '{
    // function keys F1..F12
    8'h3A,8'h3B,8'h3C,8'h3D,8'h3E,8'h3F,8'h40,8'h41,
    8'h42,8'h43,8'h44,8'h45,8'h00,8'h00,8'h00,8'h00,
    // arrows
    8'h50,8'h4F,8'h52,8'h51,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    // navigation block
    8'h49,8'h4A,8'h4D,8'h4B,8'h4E,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    // locks, print screen, pause
    8'h39,8'h53,8'h46,8'h47,8'h48,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    // keypad operators and enter
    8'h54,8'h55,8'h56,8'h57,8'h58,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    // keypad digits and period
    8'h59,8'h5A,8'h5B,8'h5C,8'h5D,8'h5E,8'h5F,8'h60,
    8'h61,8'h62,8'h63,8'h00,8'h00,8'h00,8'h00,8'h00
  };

  // Map a host key code to its HID usage, zero when unmapped
  function automatic logic [7:0] code_to_usage(input logic [15:0] code);
    logic [7:0] usage;
    usage = 8'h00;
    if (code[15:7] == 9'd0) begin
      usage = ASCII_USAGE[code[6:0]];
    end else if ((code[15:8] == 8'h01) && (code[7:4] < 4'd6)) begin
      usage = SPECIAL_USAGE[code[6:0]];
    end
    return usage;
  endfunction

endpackage

// ----- rtl/hid_keyboard_report_builder_top.sv -----
// ----------------------------------------------------------------------------
// HID keyboard report builder, top level
// Builds 6-key boot keyboard reports from key down and up events.
// ----------------------------------------------------------------------------
// One key event is taken in every cycle: busy stays low. An event is
// registered at the edge where start is high, applied to the slots and
// modifier flags in the next cycle, and a down or up event gives its report
// on out_valid/out_data in the cycle after that. The report is shown for
// exactly one cycle and the receiver cannot stall it; capture it on the
// strobe. Reports come in event order. Write enable only while no event is
// in flight (two idle cycles after the last start); with enable low, events
// change nothing and give no report.
// ----------------------------------------------------------------------------
module hid_keyboard_report_builder_top #(
  parameter int SLOT_COUNT = hkrb_pkg::SLOT_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // event channel
  input  logic                start,
  output logic                busy,
  input  hkrb_pkg::hkrb_in_t  in_data,
  // report channel
  output logic                out_valid,
  output hkrb_pkg::hkrb_out_t out_data,
  // configuration
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  logic                        in_valid_r;
  hkrb_pkg::hkrb_in_t          in_data_r;
  logic                        enable_r;
  logic [SLOT_COUNT-1:0][15:0] slots_nxt;
  hkrb_pkg::hkrb_mods_t        mods_nxt;
  logic                        report_go;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Input word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      in_data_r <= in_data;
    end
  end

  // Enable register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      enable_r <= cfg_data;
    end
  end

  hkrb_slot_bank #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_slot_bank (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_valid (in_valid_r && enable_r),
    .evt       (in_data_r),
    .slots_nxt (slots_nxt),
    .mods_nxt  (mods_nxt),
    .report_go (report_go)
  );

  hkrb_report_pack #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_report_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .report_go (report_go),
    .slots     (slots_nxt),
    .mods      (mods_nxt),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/hkrb_slot_bank.sv -----
// ----------------------------------------------------------------------------
// Pending key slot bank
// Holds the pending key slots and modifier flags, applies one event per cycle
// and presents the updated state to the report packer.
// ----------------------------------------------------------------------------
module hkrb_slot_bank #(
  parameter int SLOT_COUNT = hkrb_pkg::SLOT_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         evt_valid,
  input  hkrb_pkg::hkrb_in_t           evt,
  output logic [SLOT_COUNT-1:0][15:0]  slots_nxt,
  output hkrb_pkg::hkrb_mods_t         mods_nxt,
  output logic                         report_go
);

  logic [SLOT_COUNT-1:0][15:0] slots_r;
  hkrb_pkg::hkrb_mods_t        mods_r;
  logic                        is_down;
  logic                        found;

  assign is_down = (evt.cmd == hkrb_pkg::CMD_DOWN);

  // Apply the event to the slots and modifier flags
  always_comb begin
    slots_nxt = slots_r;
    mods_nxt  = mods_r;
    report_go = 1'b0;
    found     = 1'b0;
    if (evt_valid) begin
      unique case (evt.modifier_select)
        hkrb_pkg::MOD_NONE:  ;
        hkrb_pkg::MOD_SHIFT: mods_nxt.shift = is_down;
        hkrb_pkg::MOD_CTRL:  mods_nxt.ctrl  = is_down;
        hkrb_pkg::MOD_ALT:   mods_nxt.alt   = is_down;
        default: ;
      endcase
      unique case (evt.cmd)
        hkrb_pkg::CMD_DOWN: begin
          // fill the first empty slot, drop the key when all are taken
          report_go = 1'b1;
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!found && (slots_r[i] == 16'd0)) begin
              slots_nxt[i] = evt.key_code;
              found        = 1'b1;
            end
          end
        end
        hkrb_pkg::CMD_UP: begin
          // release every slot holding this code
          report_go = 1'b1;
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slots_r[i] == evt.key_code) begin
              slots_nxt[i] = 16'd0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Hold slot and modifier state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= '0;
      mods_r  <= '0;
    end else begin
      slots_r <= slots_nxt;
      mods_r  <= mods_nxt;
    end
  end

endmodule

// ----- rtl/hkrb_report_pack.sv -----
// ----------------------------------------------------------------------------
// Report packer
// Looks up the HID usage of each pending slot, packs mapped usages to the
// front and registers the finished report word.
// ----------------------------------------------------------------------------
module hkrb_report_pack #(
  parameter int SLOT_COUNT = hkrb_pkg::SLOT_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         report_go,
  input  logic [SLOT_COUNT-1:0][15:0]  slots,
  input  hkrb_pkg::hkrb_mods_t         mods,
  output logic                         out_valid,
  output hkrb_pkg::hkrb_out_t          out_data
);

  logic [7:0]          usage  [SLOT_COUNT];
  logic [7:0]          packed_use [hkrb_pkg::MAX_SLOTS];
  logic [2:0]          pos;
  hkrb_pkg::hkrb_out_t out_data_nxt;
  hkrb_pkg::hkrb_out_t out_data_r;
  logic                out_valid_r;

  // Look up one usage per slot
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      usage[i] = hkrb_pkg::code_to_usage(slots[i]);
    end
  end

  // Pack mapped usages to the front, skip unmapped and empty slots
  always_comb begin
    for (int j = 0; j < hkrb_pkg::MAX_SLOTS; j++) begin
      packed_use[j] = 8'h00;
    end
    pos = 3'd0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if ((usage[i] != 8'h00) && (pos < 3'(hkrb_pkg::MAX_SLOTS))) begin
        packed_use[pos] = usage[i];
        pos             = pos + 3'd1;
      end
    end
  end

  // Assemble the report word
  always_comb begin
    out_data_nxt.modifier_bits = {mods.alt, mods.shift, mods.ctrl};
    out_data_nxt.usage_one     = packed_use[0];
    out_data_nxt.usage_two     = packed_use[1];
    out_data_nxt.usage_three   = packed_use[2];
    out_data_nxt.usage_four    = packed_use[3];
    out_data_nxt.usage_five    = packed_use[4];
    out_data_nxt.usage_six     = packed_use[5];
  end

  // Strobe register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= report_go;
    end
  end

  // Report register, loaded only for a new report
  always_ff @(posedge clk) begin
    if (report_go) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
